### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sorted priority queue.
// Stand-alone header; the macros compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every rising edge of clk outside reset.
`define SPQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sorted_priority_queue: property check failed");
// Check that expr never holds on a rising edge of clk outside reset.
`define SPQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("sorted_priority_queue: forbidden condition seen");
`else
`define SPQ_ASSERT(lbl, clk, rst_n, prop)
`define SPQ_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

### hw/rtl/spq_pkg.sv
// Package of the sorted priority queue: sizes, status codes, entry and memory types.
// No dependencies; every other RTL file of the block but assert_macros.svh imports it.
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 8;

    localparam int VALUE_W    = 32;
    localparam int IN_PRIO_W  = 8;
    localparam int OUT_PRIO_W = 8;
    localparam int STATUS_W   = 2;
    localparam int OCC_W      = $clog2(CAPACITY + 1);
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int PRIO_W     = (PRIORITY_BITS < IN_PRIO_W) ? PRIORITY_BITS : IN_PRIO_W;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd3;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [PRIO_W-1:0]  prio;
    } entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_cmd_t;

    // Map a position in queue order to a memory slot of the circular store.
    function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] head,
                                                   input logic [IDX_W-1:0] offset);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= (IDX_W + 1)'(CAPACITY))
        begin
            sum = sum - (IDX_W + 1)'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

endpackage

### hw/rtl/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
// Depends on spq_pkg for field widths.
interface spq_req_if import spq_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic signed [VALUE_W-1:0]   item_value;
    logic [IN_PRIO_W-1:0]        item_priority;

    modport source (output valid, mode, item_value, item_priority, input ready);
    modport sink (input valid, mode, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic signed [VALUE_W-1:0]   out_value;
    logic [OUT_PRIO_W-1:0]       out_priority;
    logic [OCC_W-1:0]            occupancy;

    modport source (output valid, status, out_value, out_priority, occupancy, input ready);
    modport sink (input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

### hw/rtl/spq_store.sv
// Entry store of the sorted priority queue: one write port, one registered read port.
// Depends on spq_pkg for entry_t and mem_cmd_t.
module spq_store import spq_pkg::*;
(
    input  logic     clk,
    input  mem_cmd_t cmd,
    output entry_t   rd_data
);

    entry_t mem [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/spq_ctrl.sv
// Sequencer of the sorted priority queue: takes requests, walks the circular
// store to place inserts, pops the head, and holds the response register.
// Depends on spq_pkg and the channel interfaces in spq_if.sv.
module spq_ctrl import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp,
    output mem_cmd_t    mem_cmd,
    input  entry_t      rd_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_POP   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_PLACE = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [OCC_W-1:0]     count_reg, count_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    entry_t               new_reg, new_next;
    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [VALUE_W-1:0]   value_reg, value_next;
    logic [PRIO_W-1:0]    prio_reg, prio_next;
    logic [OCC_W-1:0]     occ_reg, occ_next;

    logic   can_emit;
    logic   accept;
    logic   emit;
    entry_t req_entry;

    assign can_emit  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && can_emit;
    assign accept    = req.valid && req.ready;
    assign req_entry = '{value: req.item_value, prio: req.item_priority[PRIO_W-1:0]};

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        new_next    = new_reg;
        status_next = status_reg;
        value_next  = value_reg;
        prio_next   = prio_reg;
        occ_next    = occ_reg;
        emit        = 1'b0;
        mem_cmd     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    new_next   = req_entry;
                    value_next = '0;
                    prio_next  = '0;
                    if (req.mode == MODE_INSERT)
                    begin
                        if (count_reg == OCC_W'(CAPACITY))
                        begin
                            emit        = 1'b1;
                            status_next = ST_OVERFLOW;
                            occ_next    = count_reg;
                        end
                        else if (count_reg == '0)
                        begin
                            mem_cmd.wr_en   = 1'b1;
                            mem_cmd.wr_addr = head_reg;
                            mem_cmd.wr_data = req_entry;
                            count_next      = OCC_W'(1);
                            emit            = 1'b1;
                            status_next     = ST_INSERTED;
                            occ_next        = OCC_W'(1);
                        end
                        else
                        begin
                            // fetch the tail entry, then walk toward the head
                            mem_cmd.rd_en   = 1'b1;
                            mem_cmd.rd_addr = slot_addr(head_reg,
                                                        IDX_W'(count_reg - OCC_W'(1)));
                            pos_next        = IDX_W'(count_reg);
                            state_next      = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            emit        = 1'b1;
                            status_next = ST_UNDERFLOW;
                            occ_next    = '0;
                        end
                        else
                        begin
                            mem_cmd.rd_en   = 1'b1;
                            mem_cmd.rd_addr = head_reg;
                            state_next      = S_POP;
                        end
                    end
                end
            end

            S_POP:
            begin
                if (can_emit)
                begin
                    emit        = 1'b1;
                    status_next = ST_REMOVED;
                    value_next  = rd_data.value;
                    prio_next   = rd_data.prio;
                    occ_next    = count_reg - OCC_W'(1);
                    count_next  = count_reg - OCC_W'(1);
                    head_next   = slot_addr(head_reg, IDX_W'(1));
                    state_next  = S_IDLE;
                end
            end

            S_SCAN:
            begin
                if (rd_data.prio > new_reg.prio)
                begin
                    // shift the greater entry one slot toward the tail
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = slot_addr(head_reg, pos_reg);
                    mem_cmd.wr_data = rd_data;
                    pos_next        = pos_reg - IDX_W'(1);
                    if (pos_reg == IDX_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = slot_addr(head_reg, pos_reg - IDX_W'(2));
                    end
                end
                else if (can_emit)
                begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = slot_addr(head_reg, pos_reg);
                    mem_cmd.wr_data = new_reg;
                    count_next      = count_reg + OCC_W'(1);
                    emit            = 1'b1;
                    status_next     = ST_INSERTED;
                    occ_next        = count_reg + OCC_W'(1);
                    state_next      = S_IDLE;
                end
            end

            S_PLACE:
            begin
                if (can_emit)
                begin
                    mem_cmd.wr_en   = 1'b1;
                    mem_cmd.wr_addr = slot_addr(head_reg, pos_reg);
                    mem_cmd.wr_data = new_reg;
                    count_next      = count_reg + OCC_W'(1);
                    emit            = 1'b1;
                    status_next     = ST_INSERTED;
                    occ_next        = count_reg + OCC_W'(1);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg    <= new_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        prio_reg   <= prio_next;
        occ_reg    <= occ_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.out_value    = value_reg;
    assign rsp.out_priority = OUT_PRIO_W'(prio_reg);
    assign rsp.occupancy    = occ_reg;

endmodule

### hw/rtl/sorted_priority_queue.sv
// Sorted priority queue of CAPACITY entries, lowest priority number first and
// first in, first out among equals; every request yields one response. Entries
// live in a circular single-port-write memory with a registered read.
// A remove reads the head entry and then returns it; an insert on an empty or
// full queue and a remove on an empty queue answer from the idle state; any
// other insert reads the tail entry and walks toward the head past each held
// entry with a greater priority number, as the sequencer moves one entry per
// cycle through the memory write port while reading the next one. A finished
// response waits in an output register; the next request is taken no earlier
// than the cycle in which that response is accepted, and a remove or insert that
// is ready to finish holds until the output register is free.
// Depends on spq_pkg, spq_if.sv, spq_store, spq_ctrl and assert_macros.svh.
`include "assert_macros.svh"

module sorted_priority_queue import spq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    mem_cmd_t mem_cmd;
    entry_t   rd_data;

    spq_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .mem_cmd (mem_cmd),
        .rd_data (rd_data)
    );

    spq_store u_store
    (
        .clk     (clk),
        .cmd     (mem_cmd),
        .rd_data (rd_data)
    );

    `SPQ_ASSERT(a_underflow_empty, clk, rst_n,
        (rsp.valid && rsp.status == ST_UNDERFLOW) |-> (rsp.occupancy == '0))
    `SPQ_ASSERT(a_overflow_full, clk, rst_n,
        (rsp.valid && rsp.status == ST_OVERFLOW) |-> (rsp.occupancy == OCC_W'(CAPACITY)))
    `SPQ_ASSERT(a_zero_payload, clk, rst_n,
        (rsp.valid && rsp.status != ST_REMOVED) |->
            (rsp.out_value == '0 && rsp.out_priority == '0))
    `SPQ_ASSERT_NEVER(a_removed_full, clk, rst_n,
        rsp.valid && rsp.status == ST_REMOVED && rsp.occupancy >= OCC_W'(CAPACITY))

endmodule

### dv/sorted_priority_queue_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of sorted_priority_queue: bursty requests, stalled responses.
// Depends on spq_pkg, spq_if.sv and the RTL of the block.

module sorted_priority_queue_tb;
    import spq_pkg::*;

    localparam int RANDOM_REQUESTS = 600;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 2 * CAPACITY + 8;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] value;
        logic [OUT_PRIO_W-1:0]     prio;
        logic [OCC_W-1:0]          occupancy;
    } queue_response_t;

    class queue_scoreboard;
        entry_t          held_entries[$];
        queue_response_t expected_responses[$];
        int              failures;

        function new();
            failures = 0;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        function void note_request(logic mode, logic signed [VALUE_W-1:0] value,
                                   logic [IN_PRIO_W-1:0] prio_in);
            entry_t          fresh;
            queue_response_t outcome;
            int              pos;
            fresh.value       = value;
            fresh.prio        = prio_in[PRIO_W-1:0];
            outcome.value     = '0;
            outcome.prio      = '0;
            if (mode == MODE_INSERT)
            begin
                if (held_entries.size() >= CAPACITY)
                begin
                    outcome.status = ST_OVERFLOW;
                end
                else
                begin
                    pos = 0;
                    while (pos < held_entries.size() && held_entries[pos].prio <= fresh.prio)
                    begin
                        pos++;
                    end
                    held_entries.insert(pos, fresh);
                    outcome.status = ST_INSERTED;
                end
            end
            else if (held_entries.size() == 0)
            begin
                outcome.status = ST_UNDERFLOW;
            end
            else
            begin
                outcome.value  = held_entries[0].value;
                outcome.prio   = OUT_PRIO_W'(held_entries[0].prio);
                outcome.status = ST_REMOVED;
                void'(held_entries.pop_front());
            end
            outcome.occupancy = OCC_W'(held_entries.size());
            expected_responses.push_back(outcome);
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] want,
                                    logic [VALUE_W-1:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_response(queue_response_t got);
            queue_response_t want;
            if (expected_responses.size() == 0)
            begin
                $error("response with no request pending: status %0d", got.status);
                failures++;
                return;
            end
            want = expected_responses.pop_front();
            compare_field("status", VALUE_W'(want.status), VALUE_W'(got.status));
            compare_field("out_value", want.value, got.value);
            compare_field("out_priority", VALUE_W'(want.prio), VALUE_W'(got.prio));
            compare_field("occupancy", VALUE_W'(want.occupancy), VALUE_W'(got.occupancy));
        endfunction
    endclass

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    queue_scoreboard sb;
    int              burst_left;
    int              cycle_count;
    logic [15:0]     stall_pattern;
    int              pattern_age;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        queue_response_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.status    = rsp_ch.status;
            got.value     = rsp_ch.out_value;
            got.prio      = rsp_ch.out_priority;
            got.occupancy = rsp_ch.occupancy;
            sb.check_response(got);
        end
        rsp_ch.ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        pattern_age++;
        if (pattern_age == 48)
        begin
            pattern_age   = 0;
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom) | 16'h0001;
        end
    end

    task automatic send_request(input logic mode, input logic signed [VALUE_W-1:0] value,
                                input logic [IN_PRIO_W-1:0] prio_in);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        req_ch.valid         <= 1'b1;
        req_ch.mode          <= mode;
        req_ch.item_value    <= value;
        req_ch.item_priority <= prio_in;
        do
        begin
            @(posedge clk);
        end
        while (!(req_ch.valid && req_ch.ready));
        sb.note_request(mode, value, prio_in);
        burst_left--;
    endtask

    task automatic run_phase(input int length, input int insert_pct, input int prio_span);
        logic mode;
        for (int i = 0; i < length; i++)
        begin
            mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
            send_request(mode, $urandom, IN_PRIO_W'($urandom_range(0, prio_span - 1)));
        end
    endtask

    initial
    begin
        int sent;
        int length;
        int span_pick;
        int prio_span;
        sb             = new();
        burst_left     = 0;
        stall_pattern  = 16'hffff;
        pattern_age    = 0;
        rst_n          = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.mode          = MODE_INSERT;
        req_ch.item_value    = '0;
        req_ch.item_priority = '0;
        rsp_ch.ready         = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Underflow, extremes, ties kept in arrival order, then a short drain.
        send_request(MODE_REMOVE, 32'sh0, 8'd0);
        send_request(MODE_INSERT, 32'sh7fffffff, 8'd255);
        send_request(MODE_INSERT, 32'sh80000000, 8'd0);
        send_request(MODE_INSERT, 32'sh00000000, 8'd128);
        send_request(MODE_INSERT, -32'sd1, 8'd128);
        send_request(MODE_INSERT, 32'sh00000001, 8'd128);
        send_request(MODE_INSERT, 32'sh55555555, 8'd0);
        send_request(MODE_INSERT, 32'shaaaaaaaa, 8'd255);
        send_request(MODE_INSERT, 32'sh12345678, 8'd127);
        send_request(MODE_REMOVE, -32'sd1, 8'd255);
        send_request(MODE_REMOVE, 32'sh0, 8'd0);
        send_request(MODE_REMOVE, 32'sh0, 8'd0);
        send_request(MODE_REMOVE, 32'sh0, 8'd0);
        send_request(MODE_INSERT, 32'sh00000002, 8'd128);
        send_request(MODE_REMOVE, 32'sh0, 8'd0);
        send_request(MODE_REMOVE, 32'sh0, 8'd0);
        send_request(MODE_REMOVE, 32'sh0, 8'd0);
        send_request(MODE_REMOVE, 32'sh0, 8'd0);
        send_request(MODE_REMOVE, 32'sh0, 8'd0);
        send_request(MODE_REMOVE, 32'sh0, 8'd0);

        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            length    = $urandom_range(10, 40);
            span_pick = $urandom_range(0, 2);
            prio_span = (span_pick == 0) ? 4 : ((span_pick == 1) ? 16 : 256);
            case ($urandom_range(0, 2))
                0: run_phase(length, 85, prio_span);
                1: run_phase(length, 20, prio_span);
                default: run_phase(length, 50, prio_span);
            endcase
            sent += length;
        end
        req_ch.valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_store.sv
hw/rtl/spq_ctrl.sv
hw/rtl/sorted_priority_queue.sv
dv/sorted_priority_queue_tb.sv
